// File: src/dn_syntax_checker_top_defines.svh
// Assertion macros for the DN syntax checker.
// No dependencies. Included by dnsc_core, the module that carries assertions.
`ifndef DN_SYNTAX_CHECKER_TOP_DEFINES_SVH
`define DN_SYNTAX_CHECKER_TOP_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication.
`define DNSC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dnsc assertion failed");

// Next-cycle implication.
`define DNSC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dnsc assertion failed");

`else

`define DNSC_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define DNSC_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// File: src/dnsc_pkg.sv
// Shared types and character constants for the DN syntax checker.
// No dependencies.
package dnsc_pkg;

    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_START = 2'd1,
        ESC_HEX   = 2'd2
    } esc_phase_t;

    typedef struct packed {
        logic bslash;
        logic eq;
        logic comma;
        logic special;
        logic hex;
    } char_class_t;

endpackage

// File: src/dnsc_classify.sv
// Byte classifier: separators, escape specials and hex digits.
// Depends on dnsc_pkg.
module dnsc_classify
    import dnsc_pkg::*;
(
    input  logic [7:0]  ch,
    output char_class_t cls
);

    always_comb
    begin
        cls.bslash  = (ch == CH_BSLASH);
        cls.eq      = (ch == CH_EQ);
        cls.comma   = (ch == CH_COMMA);
        cls.hex     = ((ch >= 8'h30) && (ch <= 8'h39)) ||
                      ((ch >= 8'h61) && (ch <= 8'h66)) ||
                      ((ch >= 8'h41) && (ch <= 8'h46));
        unique case (ch)
            CH_SPACE, CH_HASH, CH_EQ, CH_DQUOTE, CH_PLUS,
            CH_COMMA, CH_SEMI, CH_LT, CH_GT, CH_SQUOTE:
                cls.special = 1'b1;
            default:
                cls.special = 1'b0;
        endcase
    end

endmodule

// File: src/dnsc_core.sv
// Per-string parse state and verdict logic of the DN syntax checker.
// Depends on dnsc_pkg, dnsc_classify and the assertion macro header.
`include "dn_syntax_checker_top_defines.svh"

module dnsc_core
    import dnsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] ch,
    input  logic       last,
    output logic       verdict
);

    char_class_t cls;
    logic        failed_reg, failed_next;
    logic        want_comma_reg, want_comma_next;
    logic        sep_recent_reg, sep_recent_next;
    logic        seen_comma_reg, seen_comma_next;
    esc_phase_t  esc_reg, esc_next;

    dnsc_classify u_classify (
        .ch  (ch),
        .cls (cls)
    );

    // byte consume
    always_comb
    begin
        failed_next     = failed_reg;
        want_comma_next = want_comma_reg;
        sep_recent_next = sep_recent_reg;
        seen_comma_next = seen_comma_reg;
        esc_next        = esc_reg;
        if (!failed_reg)
        begin
            unique case (esc_reg)
                ESC_START:
                begin
                    priority if (cls.bslash || cls.special)
                        esc_next = ESC_NONE;
                    else if (cls.hex)
                        esc_next = ESC_HEX;
                    else
                        failed_next = 1'b1;
                end
                ESC_HEX:
                begin
                    if (cls.hex)
                        esc_next = ESC_NONE;
                    else
                        failed_next = 1'b1;
                end
                default:
                begin
                    esc_next = ESC_NONE;
                    priority if (cls.bslash)
                    begin
                        sep_recent_next = 1'b0;
                        esc_next        = ESC_START;
                    end
                    else if (cls.eq)
                    begin
                        if (sep_recent_reg || want_comma_reg)
                            failed_next = 1'b1;
                        else
                        begin
                            want_comma_next = 1'b1;
                            sep_recent_next = 1'b1;
                        end
                    end
                    else if (cls.comma)
                    begin
                        if (sep_recent_reg || !want_comma_reg)
                            failed_next = 1'b1;
                        else
                        begin
                            want_comma_next = 1'b0;
                            sep_recent_next = 1'b1;
                            seen_comma_next = 1'b1;
                        end
                    end
                    else
                        sep_recent_next = 1'b0;
                end
            endcase
        end
        verdict = !failed_next && (esc_next == ESC_NONE) && !sep_recent_next &&
                  seen_comma_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failed_reg     <= 1'b0;
            want_comma_reg <= 1'b0;
            sep_recent_reg <= 1'b1;
            seen_comma_reg <= 1'b0;
            esc_reg        <= ESC_NONE;
        end
        else if (fire)
        begin
            if (last)
            begin
                failed_reg     <= 1'b0;
                want_comma_reg <= 1'b0;
                sep_recent_reg <= 1'b1;
                seen_comma_reg <= 1'b0;
                esc_reg        <= ESC_NONE;
            end
            else
            begin
                failed_reg     <= failed_next;
                want_comma_reg <= want_comma_next;
                sep_recent_reg <= sep_recent_next;
                seen_comma_reg <= seen_comma_next;
                esc_reg        <= esc_next;
            end
        end
    end

    // state returns to start-of-string after the final byte
    `DNSC_ASSERT_NEXT(a_reset_after_last, clk, rst_n, fire && last,
        !failed_reg && !want_comma_reg && sep_recent_reg && !seen_comma_reg)
    // comma flag only drops at end of string
    `DNSC_ASSERT_IMPL(a_comma_clear, clk, rst_n, $fell(seen_comma_reg), $past(fire && last))
    // a passing verdict needs a clean, non-failed parse
    `DNSC_ASSERT_IMPL(a_pass_clean, clk, rst_n, fire && verdict,
        !failed_reg && (seen_comma_reg || cls.comma))

endmodule

// File: src/dn_syntax_checker_top.sv
// Flow: a byte accepted into the input register is consumed by the core when the stage fires;
// for the final byte the verdict is registered into the verdict register and offered from there.
// Throughput: one byte per cycle; a verdict still waiting stalls only the next final byte.
// Reset: rst_n, asynchronous, clears the input and output valid flags and the parse state.
// Top level of the DN syntax checker: input register, parse core, verdict register.
// Depends on dnsc_pkg and dnsc_core.
module dn_syntax_checker_top
    import dnsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       looks_like_dn
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] ch_reg;
    logic       last_reg;
    logic       out_valid_reg, out_valid_next;
    logic       looks_like_dn_reg;
    logic       stage_fire;
    logic       verdict;

    assign stage_fire = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready   = !in_valid_reg || stage_fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
            in_valid_next = in_valid;
        out_valid_next = out_valid_reg && !out_ready;
        if (stage_fire && last_reg)
            out_valid_next = 1'b1;
    end

    dnsc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (stage_fire),
        .ch      (ch_reg),
        .last    (last_reg),
        .verdict (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg   <= ch;
            last_reg <= last;
        end
        if (stage_fire && last_reg)
            looks_like_dn_reg <= verdict;
    end

    assign out_valid     = out_valid_reg;
    assign looks_like_dn = looks_like_dn_reg;

endmodule

// File: tb/sv/testbench.sv
// Testbench for dn_syntax_checker_top: streams byte strings, predicts each verdict and checks it.
// Depends on dnsc_pkg for the character constants and the escape phase type.
module testbench;
    import dnsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam logic [7:0] SPECIALS [10] = '{CH_SPACE, CH_HASH, CH_EQ, CH_DQUOTE, CH_PLUS,
                                             CH_COMMA, CH_SEMI, CH_LT, CH_GT, CH_SQUOTE};

    class dn_verdict_board;
        bit         failed;
        bit         want_comma;
        bit         sep_recent;
        bit         seen_comma;
        esc_phase_t esc;
        bit         verdicts_due[$];
        int         mismatches;
        int         bytes_seen;
        int         verdicts_checked;
        int         dn_count;

        function new();
            clear_parse();
        endfunction

        function void clear_parse();
            failed     = 1'b0;
            want_comma = 1'b0;
            sep_recent = 1'b1;
            seen_comma = 1'b0;
            esc        = ESC_NONE;
        endfunction

        function bit is_hex(logic [7:0] c);
            return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
        endfunction

        function bit is_special(logic [7:0] c);
            return c inside {CH_SPACE, CH_HASH, CH_EQ, CH_DQUOTE, CH_PLUS,
                             CH_COMMA, CH_SEMI, CH_LT, CH_GT, CH_SQUOTE};
        endfunction

        function void note_byte(logic [7:0] c, logic fin);
            bit pass;
            bytes_seen++;
            if (!failed)
            begin
                case (esc)
                    ESC_START:
                    begin
                        if (c == CH_BSLASH || is_special(c))
                            esc = ESC_NONE;
                        else if (is_hex(c))
                            esc = ESC_HEX;
                        else
                            failed = 1'b1;
                    end
                    ESC_HEX:
                    begin
                        if (is_hex(c))
                            esc = ESC_NONE;
                        else
                            failed = 1'b1;
                    end
                    default:
                    begin
                        esc = ESC_NONE;
                        if (c == CH_BSLASH)
                        begin
                            sep_recent = 1'b0;
                            esc        = ESC_START;
                        end
                        else if (c == CH_EQ)
                        begin
                            if (sep_recent || want_comma)
                                failed = 1'b1;
                            else
                            begin
                                want_comma = 1'b1;
                                sep_recent = 1'b1;
                            end
                        end
                        else if (c == CH_COMMA)
                        begin
                            if (sep_recent || !want_comma)
                                failed = 1'b1;
                            else
                            begin
                                want_comma = 1'b0;
                                sep_recent = 1'b1;
                                seen_comma = 1'b1;
                            end
                        end
                        else
                            sep_recent = 1'b0;
                    end
                endcase
            end
            if (fin)
            begin
                pass = !failed && esc == ESC_NONE && !sep_recent && seen_comma;
                if (pass)
                    dn_count++;
                verdicts_due.push_back(pass);
                clear_parse();
            end
        endfunction

        task report_mismatch(string what);
            if (mismatches < 20)
                $display("MISMATCH: %s", what);
            mismatches++;
        endtask

        task check_verdict(logic v);
            bit want;
            if (verdicts_due.size() == 0)
            begin
                report_mismatch($sformatf("verdict %b with no string pending", v));
                return;
            end
            want = verdicts_due.pop_front();
            verdicts_checked++;
            if (v !== want)
                report_mismatch($sformatf("verdict %0d: got %b, want %b",
                                          verdicts_checked, v, want));
        endtask
    endclass

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] ch        = 8'h00;
    logic       last      = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       looks_like_dn;

    dn_verdict_board board;
    logic [7:0]      str_bytes[$];
    int              bytes_sent;
    int              send_idle_pct;
    int              recv_stall_pct;
    bit              hold_req;

    dn_syntax_checker_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ch           (ch),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .looks_like_dn(looks_like_dn)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_byte(ch, last);
            if (out_valid && out_ready)
                board.check_verdict(looks_like_dn);
        end
    end

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= b;
        last     <= fin;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_string();
        int n;
        n = str_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(str_bytes[i], i == n - 1);
    endtask

    task automatic send_text(input string s);
        str_bytes.delete();
        for (int i = 0; i < s.len(); i++)
            str_bytes.push_back(s[i]);
        send_string();
    endtask

    function automatic logic [7:0] rand_hex();
        int r;
        r = $urandom_range(21);
        if (r < 10)
            return 8'(8'h30 + r);
        else if (r < 16)
            return 8'(8'h61 + r - 10);
        return 8'(8'h41 + r - 16);
    endfunction

    function automatic logic [7:0] rand_sep();
        int r;
        r = $urandom_range(2);
        if (r == 0)
            return CH_EQ;
        else if (r == 1)
            return CH_COMMA;
        return CH_BSLASH;
    endfunction

    function automatic void push_plain();
        logic [7:0] b;
        do
        begin
            if ($urandom_range(1) == 0)
                b = 8'(8'h61 + $urandom_range(25));
            else
                b = 8'($urandom_range(255));
        end
        while (b == CH_EQ || b == CH_COMMA || b == CH_BSLASH);
        str_bytes.push_back(b);
    endfunction

    function automatic void push_escape();
        int r;
        r = $urandom_range(9);
        str_bytes.push_back(CH_BSLASH);
        if (r < 2)
            str_bytes.push_back(CH_BSLASH);
        else if (r < 6)
            str_bytes.push_back(SPECIALS[$urandom_range(9)]);
        else if (r < 9)
        begin
            str_bytes.push_back(rand_hex());
            str_bytes.push_back(rand_hex());
        end
        else
            str_bytes.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void push_token();
        int n;
        n = $urandom_range(3, 1);
        repeat (n)
        begin
            if ($urandom_range(4) == 0)
                push_escape();
            else
                push_plain();
        end
    endfunction

    function automatic void build_name();
        int seps;
        int i;
        seps = $urandom_range(5, 1);
        str_bytes.delete();
        push_token();
        for (i = 0; i < seps; i++)
        begin
            str_bytes.push_back((i % 2) ? CH_COMMA : CH_EQ);
            push_token();
        end
    endfunction

    function automatic void mutate_name();
        int r;
        int pos;
        r   = $urandom_range(99);
        pos = $urandom_range(str_bytes.size() - 1);
        if (r < 12)
            str_bytes[pos] = 8'($urandom_range(255));
        else if (r < 22)
            str_bytes[pos] = rand_sep();
        else if (r < 30 && str_bytes.size() > 1)
            void'(str_bytes.pop_back());
        else if (r < 36)
            str_bytes.push_back(rand_sep());
    endfunction

    function automatic void build_noise();
        int n;
        int r;
        n = $urandom_range(6, 1);
        str_bytes.delete();
        repeat (n)
        begin
            r = $urandom_range(3);
            if (r == 0)
                str_bytes.push_back(rand_sep());
            else if (r == 1)
                str_bytes.push_back(rand_hex());
            else if (r == 2)
                str_bytes.push_back(SPECIALS[$urandom_range(9)]);
            else
                str_bytes.push_back(8'($urandom_range(255)));
        end
    endfunction

    task automatic send_random_string();
        if ($urandom_range(9) == 0)
            build_noise();
        else
        begin
            build_name();
            mutate_name();
        end
        send_string();
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int nbytes);
        int start;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start          = bytes_sent;
        while (bytes_sent - start < nbytes)
            send_random_string();
    endtask

    initial
    begin
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("a=b,c");
        send_text("=");
        send_text("a==");
        send_text("a=b,");
        send_text("a=b");
        send_text("a=\\");
        str_bytes = '{8'h00, CH_EQ, 8'hFF, CH_COMMA, 8'h80};
        send_string();

        run_phase(0, 0, 300);
        hold_req = 1'b1;
        run_phase(0, 0, 150);
        run_phase(83, 0, 250);
        run_phase(0, 83, 250);
        run_phase(9, 9, 300);

        in_valid <= 1'b0;
        @(posedge clk);
        while (board.verdicts_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.verdicts_due.size() != 0)
            board.report_mismatch("verdicts still pending at end of run");

        $display("Run covered %0d bytes and %0d verdicts (%0d strings accepted as names)",
                 board.bytes_seen, board.verdicts_checked, board.dn_count);
        $display("over open, sender-idle, receiver-stall, mixed and long hold-off phases");
        if (board.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
